>>> hdl/mcd_pkg.sv
`default_nettype none

package mcd_pkg;

  // Stream widths
  localparam int unsigned InTuserW = 2;
  localparam int unsigned InTdataW = 88;
  localparam int unsigned OutTdataW = 80;
  localparam int unsigned ReplyBytes = 6;

  // Item kinds
  localparam logic [1:0] OP_MSG = 2'd0;
  localparam logic [1:0] OP_LOAD_FAULT = 2'd1;
  localparam logic [1:0] OP_SET_META = 2'd2;
  localparam logic [1:0] OP_CLR_META = 2'd3;

  // Node roles
  localparam logic [1:0] ROLE_UNKNOWN = 2'd0;
  localparam logic [1:0] ROLE_CAPSTAN = 2'd1;
  localparam logic [1:0] ROLE_TAKEUP = 2'd2;
  localparam logic [1:0] ROLE_SUPPLY = 2'd3;

  // Command bytes
  localparam logic [7:0] CMD_DRIVE_OFF = 8'h00;
  localparam logic [7:0] CMD_DRIVE_ON = 8'h01;
  localparam logic [7:0] CMD_FAULT_STATUS = 8'h02;
  localparam logic [7:0] CMD_CALIBRATE = 8'h03;
  localparam logic [7:0] CMD_SPEED_15 = 8'h04;
  localparam logic [7:0] CMD_SPEED_30 = 8'h05;
  localparam logic [7:0] CMD_SPEED_7P5 = 8'h06;
  localparam logic [7:0] CMD_REEL_TORQUE = 8'h07;
  localparam logic [7:0] RSP_BAD_REQUEST = 8'h08;

  // Capstan speed settings
  localparam logic [1:0] SPEED_OFF = 2'd0;
  localparam logic [1:0] SPEED_7P5 = 2'd1;
  localparam logic [1:0] SPEED_15 = 2'd2;
  localparam logic [1:0] SPEED_30 = 2'd3;

  // Event codes
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_DISABLE = 3'd1;
  localparam logic [2:0] EV_ENABLE = 3'd2;
  localparam logic [2:0] EV_CALIBRATE = 3'd3;
  localparam logic [2:0] EV_SPEED = 3'd4;
  localparam logic [2:0] EV_TORQUE = 3'd5;

  // Reply lengths
  localparam logic [2:0] RLEN_NONE = 3'd0;
  localparam logic [2:0] RLEN_ONE = 3'd1;
  localparam logic [2:0] RLEN_TWO = 3'd2;
  localparam logic [2:0] RLEN_STATUS = 3'd6;

  // Message lengths that matter
  localparam logic [3:0] LEN_EMPTY = 4'd0;
  localparam logic [3:0] LEN_TORQUE_UNI = 4'd3;
  localparam logic [3:0] LEN_TORQUE_BC = 4'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic        rx_error;
    logic        is_broadcast;
    logic [3:0]  msg_len;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [15:0] fault_word_a;
    logic [15:0] fault_word_b;
    logic [7:0]  meta_mask;
  } item_t;

  typedef struct packed {
    logic [1:0]         capstan_mode;
    logic signed [15:0] torque_value;
    logic [7:0]         meta_bits;
    logic [15:0]        drv_status_a;
    logic [15:0]        drv_status_b;
  } state_t;

  typedef struct packed {
    logic [7:0]                      meta_faults;
    logic signed [15:0]              torque_cmd;
    logic [1:0]                      capstan_speed;
    logic [2:0]                      event_res;
    logic [ReplyBytes-1:0][7:0]      reply;
    logic [2:0]                      reply_len;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/mcd_decode.sv
`default_nettype none

module mcd_decode (
  input  mcd_pkg::item_t   item_i,
  input  mcd_pkg::state_t  state_i,
  input  logic [1:0]       node_role_i,
  output mcd_pkg::state_t  state_o,
  output mcd_pkg::result_t result_o
);

  logic is_reel;
  logic msg_ok;

  assign is_reel = (node_role_i == mcd_pkg::ROLE_TAKEUP) ||
                   (node_role_i == mcd_pkg::ROLE_SUPPLY);
  assign msg_ok  = !item_i.rx_error && (item_i.msg_len != mcd_pkg::LEN_EMPTY);

  // Command decode and state update
  always_comb begin
    state_o  = state_i;
    result_o = '0;

    case (item_i.op)
      mcd_pkg::OP_LOAD_FAULT: begin
        state_o.drv_status_a = item_i.fault_word_a;
        state_o.drv_status_b = item_i.fault_word_b;
      end
      mcd_pkg::OP_SET_META: begin
        state_o.meta_bits = state_i.meta_bits | item_i.meta_mask;
      end
      mcd_pkg::OP_CLR_META: begin
        state_o.meta_bits = state_i.meta_bits & ~item_i.meta_mask;
      end
      default: begin
        if (msg_ok) begin
          case (item_i.byte_0)
            mcd_pkg::CMD_DRIVE_OFF, mcd_pkg::CMD_DRIVE_ON, mcd_pkg::CMD_CALIBRATE: begin
              if (!item_i.is_broadcast) begin
                result_o.reply[0]  = item_i.byte_0;
                result_o.reply_len = mcd_pkg::RLEN_ONE;
              end
              if (item_i.byte_0 == mcd_pkg::CMD_DRIVE_OFF) begin
                result_o.event_res = mcd_pkg::EV_DISABLE;
              end else if (item_i.byte_0 == mcd_pkg::CMD_DRIVE_ON) begin
                result_o.event_res = mcd_pkg::EV_ENABLE;
              end else begin
                result_o.event_res = mcd_pkg::EV_CALIBRATE;
              end
            end
            mcd_pkg::CMD_FAULT_STATUS: begin
              if (!item_i.is_broadcast) begin
                result_o.reply[0]  = mcd_pkg::CMD_FAULT_STATUS;
                result_o.reply[1]  = state_i.meta_bits;
                result_o.reply[2]  = state_i.drv_status_a[15:8];
                result_o.reply[3]  = state_i.drv_status_a[7:0];
                result_o.reply[4]  = state_i.drv_status_b[15:8];
                result_o.reply[5]  = state_i.drv_status_b[7:0];
                result_o.reply_len = mcd_pkg::RLEN_STATUS;
              end
            end
            mcd_pkg::CMD_SPEED_15, mcd_pkg::CMD_SPEED_30, mcd_pkg::CMD_SPEED_7P5: begin
              if (node_role_i == mcd_pkg::ROLE_CAPSTAN) begin
                if (!item_i.is_broadcast) begin
                  result_o.reply[0]  = item_i.byte_0;
                  result_o.reply_len = mcd_pkg::RLEN_ONE;
                end
                if (item_i.byte_0 == mcd_pkg::CMD_SPEED_15) begin
                  state_o.capstan_mode = mcd_pkg::SPEED_15;
                end else if (item_i.byte_0 == mcd_pkg::CMD_SPEED_30) begin
                  state_o.capstan_mode = mcd_pkg::SPEED_30;
                end else begin
                  state_o.capstan_mode = mcd_pkg::SPEED_7P5;
                end
                result_o.event_res = mcd_pkg::EV_SPEED;
              end
            end
            mcd_pkg::CMD_REEL_TORQUE: begin
              if (is_reel) begin
                if (item_i.is_broadcast) begin
                  // broadcast carries both reels; pick our own pair
                  if (item_i.msg_len == mcd_pkg::LEN_TORQUE_BC) begin
                    if (node_role_i == mcd_pkg::ROLE_TAKEUP) begin
                      state_o.torque_value = {item_i.byte_1, item_i.byte_2};
                    end else begin
                      state_o.torque_value = {item_i.byte_3, item_i.byte_4};
                    end
                    result_o.event_res = mcd_pkg::EV_TORQUE;
                  end
                end else if (item_i.msg_len != mcd_pkg::LEN_TORQUE_UNI) begin
                  result_o.reply[0]  = mcd_pkg::RSP_BAD_REQUEST;
                  result_o.reply_len = mcd_pkg::RLEN_ONE;
                end else begin
                  result_o.reply[0]    = mcd_pkg::CMD_REEL_TORQUE;
                  result_o.reply[1]    = state_i.meta_bits;
                  result_o.reply_len   = mcd_pkg::RLEN_TWO;
                  state_o.torque_value = {item_i.byte_1, item_i.byte_2};
                  result_o.event_res   = mcd_pkg::EV_TORQUE;
                end
              end
            end
            default: begin
              // unknown command: ignored
            end
          endcase
        end
      end
    endcase

    // Result reports settings as they stand after this item
    result_o.capstan_speed = state_o.capstan_mode;
    result_o.torque_cmd    = state_o.torque_value;
    result_o.meta_faults   = state_o.meta_bits;
  end

endmodule

`default_nettype wire

>>> hdl/motor_command_decoder.sv
// An accepted item is held in the input register, decoded from there, and its result is
// captured in the result register, which offers it on the master side.
// Throughput: one item per cycle while m_axis_tready is high; both registers are ready-gated.
// Reset (rst_ni low, asynchronous): node role, capstan speed, torque, meta faults and both
// driver status words go to zero; both pipeline registers are emptied.
`default_nettype none

module motor_command_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: node_role
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_wdata_i,
  // input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // op
  input  logic [mcd_pkg::InTuserW-1:0]   s_axis_tuser,
  // rx_error, is_broadcast, msg_len, byte_0..byte_4, fault_word_a, fault_word_b,
  // meta_mask, zero pad
  input  logic [mcd_pkg::InTdataW-1:0]   s_axis_tdata,
  // result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // reply_len, reply_0..reply_5, event_res, capstan_speed, torque_cmd, meta_faults
  output logic [mcd_pkg::OutTdataW-1:0]  m_axis_tdata
);

  logic              in_valid_q;
  mcd_pkg::item_t    in_q;
  logic              out_valid_q;
  mcd_pkg::result_t  out_q;
  mcd_pkg::state_t   state_q;
  mcd_pkg::state_t   state_d;
  mcd_pkg::result_t  result_d;
  logic [1:0]        role_q;
  mcd_pkg::item_t    s_item;
  logic              advance;
  logic              s_accept;

  // Unpack the input item
  always_comb begin
    s_item.op           = s_axis_tuser;
    s_item.rx_error     = s_axis_tdata[0];
    s_item.is_broadcast = s_axis_tdata[1];
    s_item.msg_len      = s_axis_tdata[5:2];
    s_item.byte_0       = s_axis_tdata[13:6];
    s_item.byte_1       = s_axis_tdata[21:14];
    s_item.byte_2       = s_axis_tdata[29:22];
    s_item.byte_3       = s_axis_tdata[37:30];
    s_item.byte_4       = s_axis_tdata[45:38];
    s_item.fault_word_a = s_axis_tdata[61:46];
    s_item.fault_word_b = s_axis_tdata[77:62];
    s_item.meta_mask    = s_axis_tdata[85:78];
  end

  // Handshake: item moves to the result register when that register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  mcd_decode u_decode (
    .item_i      (in_q),
    .state_i     (state_q),
    .node_role_i (role_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  // Control and node state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      role_q      <= mcd_pkg::ROLE_UNKNOWN;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        role_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q <= s_item;
    end
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
